### rtl/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

   // operand widths
   localparam int MOD_WIDTH  = 32;
   localparam int EXP_WIDTH  = 32;
   localparam int BASE_WIDTH = 64;

   // port widths fixed by the interface
   localparam int MOD_PORT_WIDTH  = 32;
   localparam int BASE_PORT_WIDTH = 64;
   localparam int EXP_PORT_WIDTH  = 32;

   // derived widths
   localparam int STEP_CNT_WIDTH = $clog2(BASE_WIDTH + 1);
   localparam int BIT_CNT_WIDTH  = $clog2(EXP_WIDTH + 1);
   localparam int SUM_WIDTH      = MOD_WIDTH + 2;

   // command into the serial modular multiplier
   typedef struct packed {
      logic                      start;
      logic [BASE_WIDTH-1:0]     x;
      logic [MOD_WIDTH-1:0]      y;
      logic [STEP_CNT_WIDTH-1:0] steps;
   } mexp_cmd_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_BIT,
      ST_MUL,
      ST_SQR,
      ST_DONE
   } mexp_state_type;

endpackage

`default_nettype wire

### rtl/mexp_serial_mul.sv
`default_nettype none

// shift-and-add modular multiplier, one bit of x per cycle, msb first:
// result = (top "steps" bits of x) * y mod m
module mexp_serial_mul import mexp_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mexp_cmd_type         cmd,
   input  wire logic [MOD_WIDTH-1:0] modulus,
   output logic                      done,
   output logic [MOD_WIDTH-1:0]      result
);

   logic [BASE_WIDTH-1:0]     shift_ff, shift_in;
   logic [MOD_WIDTH-1:0]      y_ff, y_in;
   logic [MOD_WIDTH-1:0]      r_ff, r_in;
   logic [STEP_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   logic [SUM_WIDTH-1:0]      sum;
   logic [SUM_WIDTH:0]        diff1;
   logic [SUM_WIDTH:0]        diff2;
   logic [MOD_WIDTH-1:0]      r_step;

   // one step: r = (2r + bit*y) mod m, the sum stays below 3m
   always_comb begin
      sum = {1'b0, r_ff, 1'b0};
      if (shift_ff[BASE_WIDTH-1]) begin
         sum = sum + SUM_WIDTH'(y_ff);
      end
      diff1 = {1'b0, sum} - (SUM_WIDTH + 1)'(modulus);
      diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
      if (!diff2[SUM_WIDTH]) begin
         r_step = diff2[MOD_WIDTH-1:0];
      end else if (!diff1[SUM_WIDTH]) begin
         r_step = diff1[MOD_WIDTH-1:0];
      end else begin
         r_step = sum[MOD_WIDTH-1:0];
      end
   end

   // load on start, then step until the count runs out
   always_comb begin
      shift_in = shift_ff;
      y_in     = y_ff;
      r_in     = r_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         shift_in = cmd.x;
         y_in     = cmd.y;
         r_in     = '0;
         cnt_in   = cmd.steps;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[BASE_WIDTH-2:0], 1'b0};
         r_in     = r_step;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == STEP_CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      y_ff     <= y_in;
      r_ff     <= r_in;
      cnt_ff   <= cnt_in;
   end

   assign done   = done_ff;
   assign result = r_ff;

endmodule

`default_nettype wire

### rtl/modular_exponentiation.sv
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-------------------------------------
// request   | in        | req_valid/req_ready  | req_base_value, req_exponent_value
// response  | out       | rsp_valid/rsp_ready  | rsp_power_result
// csr       | in        | csr_write_en         | csr_write_data (modulus)
//
// one request at a time: the base is reduced in 64 serial steps, then for each
// of the 32 exponent bits a 32-step multiply (bit set) and a 32-step square
// run on the one shared serial multiplier.
// a zero modulus answers 0 in the cycle after the request.
// reset is synchronous; the modulus resets to 1.
// the response register holds until rsp_ready; req_ready is low meanwhile.
`default_nettype none

module modular_exponentiation import mexp_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [BASE_PORT_WIDTH-1:0] req_base_value,
   input  wire logic [EXP_PORT_WIDTH-1:0]  req_exponent_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [MOD_PORT_WIDTH-1:0]       rsp_power_result,
   input  wire logic                       csr_write_en,
   input  wire logic [MOD_PORT_WIDTH-1:0]  csr_write_data
);

   mexp_state_type           state_ff, state_in;
   logic [MOD_WIDTH-1:0]     modulus_ff;
   logic [EXP_WIDTH-1:0]     exp_ff, exp_in;
   logic [BIT_CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic [MOD_WIDTH-1:0]     base_ff, base_in;
   logic [MOD_WIDTH-1:0]     acc_ff, acc_in;
   logic [MOD_WIDTH-1:0]     result_ff, result_in;

   mexp_cmd_type             cmd;
   logic                     mul_done;
   logic [MOD_WIDTH-1:0]     mul_result;
   logic                     req_fire;
   logic                     mod_zero;
   logic                     exp_end;

   assign req_fire = req_valid && req_ready;
   assign mod_zero = (modulus_ff == '0);
   assign exp_end  = (bit_cnt_ff == BIT_CNT_WIDTH'(EXP_WIDTH));

   mexp_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .modulus (modulus_ff),
      .done    (mul_done),
      .result  (mul_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = mod_zero ? ST_DONE : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            if (exp_end) begin
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_SQR;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            if (mul_done) begin
               state_in = ST_BIT;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and multiplier commands
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.start = 1'b0;
      cmd.x     = {base_ff, {(BASE_WIDTH - MOD_WIDTH){1'b0}}};
      cmd.y     = base_ff;
      cmd.steps = STEP_CNT_WIDTH'(MOD_WIDTH);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // base mod m as base * 1 over all base bits
            cmd.start = req_fire && !mod_zero;
            cmd.x     = BASE_WIDTH'(req_base_value);
            cmd.y     = MOD_WIDTH'(1);
            cmd.steps = STEP_CNT_WIDTH'(BASE_WIDTH);
         end
         ST_BIT: begin
            cmd.start = !exp_end;
            if (exp_ff[0]) begin
               cmd.x = {acc_ff, {(BASE_WIDTH - MOD_WIDTH){1'b0}}};
            end
         end
         ST_MUL: begin
            // square follows right away
            cmd.start = mul_done;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd.start = 1'b0;
         end
      endcase
   end

   // operand registers
   always_comb begin
      exp_in     = exp_ff;
      bit_cnt_in = bit_cnt_ff;
      base_in    = base_ff;
      acc_in     = acc_ff;
      result_in  = result_ff;
      case (state_ff)
         ST_IDLE: begin
            exp_in     = EXP_WIDTH'(req_exponent_value);
            bit_cnt_in = '0;
            acc_in     = MOD_WIDTH'(1);
            result_in  = '0;
         end
         ST_REDUCE: begin
            if (mul_done) begin
               base_in = mul_result;
            end
         end
         ST_BIT: begin
            if (exp_end) begin
               result_in = acc_ff;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               acc_in = mul_result;
            end
         end
         ST_SQR: begin
            if (mul_done) begin
               base_in    = mul_result;
               exp_in     = exp_ff >> 1;
               bit_cnt_in = bit_cnt_ff + 1'b1;
            end
         end
         default: begin
            result_in = result_ff;
         end
      endcase
   end

   // control state and modulus register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         modulus_ff <= MOD_WIDTH'(1);
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            modulus_ff <= MOD_WIDTH'(csr_write_data);
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      exp_ff     <= exp_in;
      bit_cnt_ff <= bit_cnt_in;
      base_ff    <= base_in;
      acc_ff     <= acc_in;
      result_ff  <= result_in;
   end

   assign rsp_power_result = MOD_PORT_WIDTH'(result_ff);

endmodule

`default_nettype wire

### rtl/mexp_checker.sv
`default_nettype none

module mexp_checker import mexp_pkg::*; (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [MOD_PORT_WIDTH-1:0]  rsp_power_result
);

   // a waiting response holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_power_result))
      else $error("response changed while stalled");

   // one request in flight: no new request while a response waits
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response pending");

   // an accepted request makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after a request");

   // taking the response frees the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready && !rsp_valid)
      else $error("not ready after response taken");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_power_result (rsp_power_result)
);

`default_nettype wire

### tb/modular_exponentiation_tb.sv
`timescale 1ns / 1ps

module modular_exponentiation_tb;
   import mexp_pkg::*;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int DRAIN_CYCLES  = 2300;
   localparam int PHASE_ITEMS   = 40;
   localparam int RANDOM_PHASES = 7;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [BASE_PORT_WIDTH-1:0] req_base_value = '0;
   logic [EXP_PORT_WIDTH-1:0]  req_exponent_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [MOD_PORT_WIDTH-1:0]  rsp_power_result;
   logic                       csr_write_en = 1'b0;
   logic [MOD_PORT_WIDTH-1:0]  csr_write_data = '0;

   // shadow of the modulus register and pending expected powers
   logic [MOD_PORT_WIDTH-1:0]  modulus_setting = 32'd1;
   logic [MOD_PORT_WIDTH-1:0]  expected_powers[$];
   int                         error_count = 0;
   int                         cycle_count = 0;
   bit                         calm = 1'b0;

   modular_exponentiation u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_base_value     (req_base_value),
      .req_exponent_value (req_exponent_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_power_result   (rsp_power_result),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // right-to-left square and multiply, all products reduced by the modulus
   function automatic logic [MOD_PORT_WIDTH-1:0] mod_power(
      input logic [BASE_PORT_WIDTH-1:0] base,
      input logic [EXP_PORT_WIDTH-1:0]  expo,
      input logic [MOD_PORT_WIDTH-1:0]  modulus
   );
      logic [63:0] m;
      logic [63:0] b;
      logic [63:0] acc;
      // zero modulus answers zero for everything
      if (modulus[MOD_WIDTH-1:0] == '0)
         return '0;
      m = 64'(modulus[MOD_WIDTH-1:0]);
      b = base % m;
      acc = 64'd1;
      for (int i = 0; i < EXP_WIDTH; i++) begin
         if (expo[i])
            acc = (acc * b) % m;
         b = (b * b) % m;
      end
      return acc[MOD_PORT_WIDTH-1:0];
   endfunction

   // idle length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 60);
   endfunction

   // send one request, record its expected power once accepted
   task automatic send_request(input logic [BASE_PORT_WIDTH-1:0] base,
                               input logic [EXP_PORT_WIDTH-1:0] expo);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_base_value = base;
      req_exponent_value = expo;
      do
         @(posedge clock);
      while (!req_ready);
      expected_powers.push_back(mod_power(base, expo, modulus_setting));
   endtask

   // hold off until every expected response has come back
   task automatic drain_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_powers.size() != 0)
         @(posedge clock);
   endtask

   // modulus is only written while the block is idle
   task automatic write_modulus(input logic [MOD_PORT_WIDTH-1:0] value);
      drain_responses();
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      modulus_setting = value;
   endtask

   // modulus left at its reset value of one
   task automatic test_reset_modulus();
      send_request(64'd5, 32'd0);
      send_request(64'd0, 32'd5);
      send_request('1, '1);
   endtask

   // field extremes under the largest modulus
   task automatic test_max_modulus();
      write_modulus(32'hFFFF_FFFF);
      send_request('1, '1);
      send_request(64'd0, 32'd0);
      send_request(64'd0, 32'd7);
      send_request(64'd1, '1);
      send_request(64'h0000_0000_FFFF_FFFF, 32'd3);
      send_request(64'hDEAD_BEEF_1234_5678, 32'h8000_0000);
      send_request(64'h8000_0000_0000_0001, 32'd65537);
   endtask

   // small moduli, including a textbook rsa key pair
   task automatic test_small_moduli();
      write_modulus(32'd2);
      send_request(64'd3, '1);
      send_request(64'd4, 32'd1);
      write_modulus(32'd3233);
      send_request(64'd65, 32'd17);
      send_request(64'd2790, 32'd2753);
      send_request(64'd3233, 32'd9);
   endtask

   // zero modulus answers zero, even for a zero exponent
   task automatic test_zero_modulus();
      write_modulus(32'd0);
      send_request(64'd9, 32'd0);
      send_request('1, '1);
      send_request(64'd12345, 32'd3);
   endtask

   // random requests over a series of moduli
   task automatic test_random_requests();
      logic [BASE_PORT_WIDTH-1:0] base;
      logic [EXP_PORT_WIDTH-1:0]  expo;
      logic [MOD_PORT_WIDTH-1:0]  modulus;
      int                         kind;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: modulus = {1'b1, 31'($urandom)};
            1: modulus = $urandom_range(2, 255);
            2: modulus = $urandom;
            3: modulus = 32'hFFFF_FFFF;
            4: modulus = $urandom_range(3, 65535);
            5: modulus = 32'd1;
            default: modulus = $urandom;
         endcase
         write_modulus(modulus);
         calm = (phase == 2) || (phase == 5);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // pause mid phase until all responses are back
            if (n == PHASE_ITEMS / 2)
               drain_responses();
            kind = $urandom_range(0, 9);
            case (kind)
               0: expo = '0;
               1: expo = 32'd1 << $urandom_range(0, 31);
               2: expo = $urandom_range(1, 255);
               3: expo = 32'd65537;
               default: expo = $urandom;
            endcase
            kind = $urandom_range(0, 9);
            case (kind)
               0: base = '0;
               1: base = 64'($urandom) % ((modulus == 0) ? 64'd1 : 64'(modulus));
               2: base = 64'(modulus) * 64'($urandom);
               3: base = '1;
               default: base = {$urandom, $urandom};
            endcase
            send_request(base, expo);
         end
      end
      calm = 1'b0;
   endtask

   // response side stalls
   initial begin
      int gap;
      forever begin
         gap = pick_gap();
         repeat (gap) begin
            @(negedge clock);
            rsp_ready = 1'b0;
         end
         @(negedge clock);
         rsp_ready = 1'b1;
         repeat ($urandom_range(0, 20)) @(negedge clock);
      end
   end

   // compare each accepted response with the oldest expected power
   always @(posedge clock) begin
      logic [MOD_PORT_WIDTH-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_powers.size() == 0) begin
            $error("power_result: no request pending, actual %0h", rsp_power_result);
            error_count++;
         end else begin
            want = expected_powers.pop_front();
            if (rsp_power_result !== want) begin
               $error("power_result: expected %0h, actual %0h", want, rsp_power_result);
               error_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("modular_exponentiation regression: fail");
         $finish;
      end
   end

   // test sequence
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_modulus();
      test_max_modulus();
      test_small_moduli();
      test_zero_modulus();
      test_random_requests();
      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("modular_exponentiation regression: pass");
      else
         $display("modular_exponentiation regression: fail");
      $finish;
   end

endmodule

### sim.f
rtl/mexp_pkg.sv
rtl/mexp_serial_mul.sv
rtl/modular_exponentiation.sv
rtl/mexp_checker.sv
tb/modular_exponentiation_tb.sv
